### sv/icf_pkg.sv
package icf_pkg;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int unsigned TAB_IW = 5;
    localparam int unsigned XW = 31;
    localparam int unsigned ZW = 26;
    localparam int unsigned CFG_IW = 2;
    localparam int unsigned CFG_DW = 17;

    localparam logic [CFG_IW-1:0] CFG_GYRO_GAIN = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BLEND_ALPHA = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MAG_LOW = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_MAG_HIGH = 2'd3;

    localparam logic [15:0] GAIN_RESET = 16'd10;
    localparam logic [15:0] ALPHA_RESET = 16'd64225;
    localparam logic [16:0] MAG_LOW_RESET = 17'd8192;
    localparam logic [16:0] MAG_HIGH_RESET = 17'd32768;

    localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic               corrected;
    } out_item_t;

    typedef struct packed {
        logic             load_in;
        logic             prep;
        logic             integ;
        logic             step;
        logic [CNT_W-1:0] step_idx;
        logic             blend_mul;
        logic             blend_sum;
        logic             out_load;
    } icf_cmd_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [TAB_IW-1:0] idx);
        logic signed [ZW-1:0] r;
        unique case (idx)
            5'd0:    r = 26'sd2949120;
            5'd1:    r = 26'sd1740967;
            5'd2:    r = 26'sd919879;
            5'd3:    r = 26'sd466945;
            5'd4:    r = 26'sd234379;
            5'd5:    r = 26'sd117304;
            5'd6:    r = 26'sd58666;
            5'd7:    r = 26'sd29335;
            5'd8:    r = 26'sd14668;
            5'd9:    r = 26'sd7334;
            5'd10:   r = 26'sd3667;
            5'd11:   r = 26'sd1833;
            5'd12:   r = 26'sd917;
            5'd13:   r = 26'sd458;
            5'd14:   r = 26'sd229;
            5'd15:   r = 26'sd115;
            5'd16:   r = 26'sd57;
            5'd17:   r = 26'sd29;
            5'd18:   r = 26'sd14;
            5'd19:   r = 26'sd7;
            5'd20:   r = 26'sd4;
            5'd21:   r = 26'sd2;
            5'd22:   r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [XW-1:0] scale_in(input logic signed [15:0] v);
        return {{(XW-28){v[15]}}, v, 12'h000};
    endfunction

    function automatic logic [16:0] abs17(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

endpackage

### sv/icf_ctrl.sv
module icf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output icf_pkg::icf_cmd_t cmd
);
    import icf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_CORD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                state_next = S_CORD;
                cnt_next   = '0;
            end
            S_CORD: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL: begin
                state_next = S_SUM;
            end
            S_SUM: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.load_in   = (state_reg == S_IDLE) && s_valid;
        cmd.prep      = (state_reg == S_PREP);
        cmd.step      = (state_reg == S_CORD);
        cmd.integ     = (state_reg == S_CORD) && (cnt_reg == '0);
        cmd.step_idx  = cnt_reg;
        cmd.blend_mul = (state_reg == S_MUL);
        cmd.blend_sum = (state_reg == S_SUM);
        cmd.out_load  = (state_reg == S_OUT) && out_free;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### sv/icf_dpath.sv
module icf_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  icf_pkg::icf_cmd_t           cmd,
    input  icf_pkg::in_item_t           s_data,
    output icf_pkg::out_item_t          m_data,
    input  logic                        cfg_we,
    input  logic [icf_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [icf_pkg::CFG_DW-1:0]  cfg_wdata
);
    import icf_pkg::*;

    logic [15:0] gain_reg;
    logic [15:0] alpha_reg;
    logic [16:0] mag_low_reg;
    logic [16:0] mag_high_reg;

    in_item_t             in_reg;
    logic signed [32:0]   gprod_x_reg, gprod_y_reg;
    logic                 corr_reg;
    logic signed [31:0]   pitch_reg, roll_reg;
    logic signed [XW-1:0] x_reg [2];
    logic signed [XW-1:0] y_reg [2];
    logic signed [ZW-1:0] z_reg [2];
    logic                 zero_reg [2];
    logic signed [48:0]   bp_keep_reg [2];
    logic signed [48:0]   bp_acc_reg [2];
    out_item_t            out_reg;

    logic signed [15:0]   raw_y [2];
    logic signed [15:0]   raw_x [2];
    logic signed [XW-1:0] x_init [2];
    logic signed [XW-1:0] y_init [2];
    logic signed [ZW-1:0] z_init [2];
    logic signed [XW-1:0] x_step [2];
    logic signed [XW-1:0] y_step [2];
    logic signed [ZW-1:0] z_step [2];
    logic signed [ZW-1:0] tab_val;
    logic [16:0]          mag;
    logic signed [33:0]   pitch_int, roll_int;
    logic signed [31:0]   angle [2];
    logic signed [ZW-1:0] acc [2];
    logic signed [49:0]   bsum [2];
    logic signed [16:0]   keep_w;
    logic signed [17:0]   acc_w;

    // pitch lane uses (ay, az), roll lane uses (ax, az)
    assign raw_y[0] = in_reg.accel_y;
    assign raw_x[0] = in_reg.accel_z;
    assign raw_y[1] = in_reg.accel_x;
    assign raw_x[1] = in_reg.accel_z;

    assign tab_val = atan_entry(TAB_IW'(cmd.step_idx));

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic signed [XW-1:0] xs, ys;
            xs = scale_in(raw_x[l]);
            ys = scale_in(raw_y[l]);
            x_init[l] = xs;
            y_init[l] = ys;
            z_init[l] = '0;
            if (xs < 0) begin
                if (ys >= 0) begin
                    x_init[l] = ys;
                    y_init[l] = -xs;
                    z_init[l] = DEG90;
                end else begin
                    x_init[l] = -ys;
                    y_init[l] = xs;
                    z_init[l] = -DEG90;
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic signed [XW-1:0] xsh, ysh;
            xsh = x_reg[l] >>> cmd.step_idx;
            ysh = y_reg[l] >>> cmd.step_idx;
            if (y_reg[l] >= 0) begin
                x_step[l] = x_reg[l] + ysh;
                y_step[l] = y_reg[l] - xsh;
                z_step[l] = z_reg[l] + tab_val;
            end else begin
                x_step[l] = x_reg[l] - ysh;
                y_step[l] = y_reg[l] + xsh;
                z_step[l] = z_reg[l] - tab_val;
            end
        end
    end

    assign mag = abs17(in_reg.accel_x) + abs17(in_reg.accel_y) + abs17(in_reg.accel_z);

    assign pitch_int = 34'(pitch_reg) + 34'(gprod_x_reg);
    assign roll_int  = 34'(roll_reg) - 34'(gprod_y_reg);

    assign angle[0] = pitch_reg;
    assign angle[1] = roll_reg;
    assign keep_w   = $signed({1'b0, alpha_reg});
    assign acc_w    = 18'sd65536 - 18'($signed({1'b0, alpha_reg}));

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            acc[l]  = zero_reg[l] ? '0 : z_reg[l];
            bsum[l] = 50'(bp_keep_reg[l]) + 50'(bp_acc_reg[l]) + 50'sd32768;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_RESET;
            alpha_reg    <= ALPHA_RESET;
            mag_low_reg  <= MAG_LOW_RESET;
            mag_high_reg <= MAG_HIGH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GYRO_GAIN:   gain_reg     <= cfg_wdata[15:0];
                CFG_BLEND_ALPHA: alpha_reg    <= cfg_wdata[15:0];
                CFG_MAG_LOW:     mag_low_reg  <= cfg_wdata;
                CFG_MAG_HIGH:    mag_high_reg <= cfg_wdata;
                default:         gain_reg     <= gain_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg <= '0;
            roll_reg  <= '0;
        end else if (cmd.integ) begin
            pitch_reg <= sat32(pitch_int);
            roll_reg  <= sat32(roll_int);
        end else if (cmd.blend_sum && corr_reg) begin
            pitch_reg <= sat32(bsum[0][49:16]);
            roll_reg  <= sat32(bsum[1][49:16]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.prep) begin
            gprod_x_reg <= in_reg.gyro_x * $signed({1'b0, gain_reg});
            gprod_y_reg <= in_reg.gyro_y * $signed({1'b0, gain_reg});
            corr_reg    <= (mag > mag_low_reg) && (mag < mag_high_reg);
        end
        for (int l = 0; l < 2; l++) begin
            if (cmd.prep) begin
                x_reg[l]    <= x_init[l];
                y_reg[l]    <= y_init[l];
                z_reg[l]    <= z_init[l];
                zero_reg[l] <= (raw_x[l] == '0) && (raw_y[l] == '0);
            end else if (cmd.step) begin
                x_reg[l] <= x_step[l];
                y_reg[l] <= y_step[l];
                z_reg[l] <= z_step[l];
            end
            if (cmd.blend_mul) begin
                bp_keep_reg[l] <= keep_w * angle[l];
                bp_acc_reg[l]  <= acc_w * acc[l];
            end
        end
        if (cmd.out_load) begin
            out_reg.pitch     <= pitch_reg;
            out_reg.roll      <= roll_reg;
            out_reg.corrected <= corr_reg;
        end
    end

    assign m_data = out_reg;

endmodule

### sv/imu_complementary_filter.sv
// Pitch/roll complementary filter. Each transfer on the s_ side carries one raw
// sample set (three accelerometer axes, two gyro axes); each transfer on the m_
// side returns the updated Q16.16-degree pitch and roll and a flag telling whether
// the accelerometer blend was applied. Gyro rates are integrated with gyro_gain;
// when |ax|+|ay|+|az| lies strictly between magnitude_low and magnitude_high both
// angles are blended with CORDIC atan2 tilt angles using blend_alpha. A sample
// passes a prep state, CORDIC_STEPS states in which both CORDIC lanes run one
// micro-rotation per cycle, a blend-multiply and a blend-sum state, and an output
// state that loads the result and raises m_valid once the output register is free;
// the next sample can be taken in the cycle after that load. The output register
// holds it until the m_ side takes it. The user must write configuration registers
// through cfg_we/cfg_index/cfg_wdata only while the block idles (not enforced).
module imu_complementary_filter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  icf_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output icf_pkg::out_item_t          m_data,
    input  logic                        cfg_we,
    input  logic [icf_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [icf_pkg::CFG_DW-1:0]  cfg_wdata
);
    import icf_pkg::*;

    icf_cmd_t cmd;

    icf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    icf_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
